/* hw/rtl/aarm_pkg.sv */
// Shared types, constants and arithmetic helpers for the axis-angle rotation matrix unit.
// Used by the front cells, the divider cells and the top level; depends on nothing else.
`default_nettype none

package aarm_pkg;

	localparam int unsigned CordicSteps = 30;
	localparam int unsigned FrontCells  = 32;
	localparam int unsigned DivCells    = 31;

	// Q.30 working word, wide enough for every intermediate of the datapath.
	typedef logic signed [33:0] q30_t;

	localparam q30_t             CORDIC_GAIN = 34'sd652032874;
	localparam q30_t             Q30_ONE     = 34'sd1073741824;
	localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic [15:0]      Q214_ONE    = 16'd16384;

	// Register index decoded from the APB byte address.
	localparam logic REG_TOL = 1'b0;

	// Arctangent of 2^-i in Q.30; the last two entries pad the table to the index range.
	localparam logic [31:0] STEP_ANGLE [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000000, 32'h00000000
	};

	// Per-item flags; bit 0 is x, bit 1 is y, bit 2 is z.
	typedef struct packed {
		logic [2:0] zero;
		logic       zsum;
		logic [2:0] pos;
		logic [2:0] neg;
	} side_t;

	// Item state in the front chain: CORDIC rotation plus one square root digit per cell.
	typedef struct packed {
		logic            valid;
		q30_t            cx;
		q30_t            cy;
		q30_t            cz;
		logic            neg_cos;
		logic [34:0]     sq_rem;
		logic [31:0]     sq_root;
		logic [31:0]     sq_pend;
		logic [2:0][15:0] mag;
		side_t           side;
	} front_t;

	// Item state in the divider chain: three lanes share one divisor.
	typedef struct packed {
		logic            valid;
		q30_t            s;
		q30_t            c;
		logic [31:0]     divisor;
		logic [30:0]     low;
		logic [2:0][31:0] rem;
		logic [2:0][30:0] quo;
		side_t           side;
	} div_t;

	function automatic q30_t mul30(input q30_t a, input q30_t b);
		logic signed [67:0] p;
		p = 68'(a) * 68'(b) + 68'sd536870912;
		return q30_t'(p >>> 30);
	endfunction

	function automatic logic [15:0] to_q214(input logic signed [35:0] v);
		logic signed [35:0] r;
		r = (v + 36'sd32768) >>> 16;
		if (r > 36'sd32767) begin
			return 16'h7FFF;
		end else if (r < -36'sd32768) begin
			return 16'h8000;
		end
		return r[15:0];
	endfunction

	// Sum of two Q.30 terms rounded and saturated to Q2.14.
	function automatic logic [15:0] q214_of(input q30_t a, input q30_t b);
		return to_q214(36'(a) + 36'(b));
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/axis_angle_rotation_matrix_unit.sv */
// Top level of the axis-angle to rotation matrix unit: input stages, cell chains, products.
// Depends on aarm_pkg, aarm_front_cell and aarm_div_cell.
//
// Usage: an item on the s_axis channel carries an angle (Q4.12 radians) and an axis
// (three Q8.8 components of any length). For each item the m_axis channel returns one
// item with the nine entries of the rotation matrix in Q2.14, row by row.
// The APB port holds one register, the axis zero tolerance, at byte address 0.
// It should be written only while no item is in flight.
// The item passes 68 registers: two input stages, the 32 front cells (one square root
// digit each, the CORDIC rotation riding along), the 31 divider cells (one quotient bit
// each), two product stages and the output register; the first of them loads at the
// accepting edge. Throughput is one item per cycle while the receiver takes results.
// The whole pipeline advances as one: whenever the output register is empty or being
// taken, every stage moves. If the receiver stalls with a result waiting, s_axis_tready
// drops in the same cycle and every item in flight holds its place; nothing is lost.
// Reset clears all valid bits and sets the tolerance to 1; payload registers keep junk
// that is never shown.
`default_nettype none

module axis_angle_rotation_matrix_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // angle, axis_x, axis_y, axis_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	// Configuration register.
	logic [7:0] tol_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == aarm_pkg::REG_TOL);
	assign prdata = (paddr[2] == aarm_pkg::REG_TOL) ? {24'd0, tol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 8'd1;
		end else if (cfg_wr) begin
			tol_q <= pwdata[7:0];
		end
	end

	// The pipeline moves whenever the output register can take a new result.
	logic adv;
	logic out_valid_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	// Stage 1: angle wrap to [-pi, pi], magnitudes, squares and zero tests.
	logic signed [15:0]  in_ang;
	logic signed [35:0]  ang_full;
	logic signed [35:0]  ang_wrap;
	logic [2:0][15:0]    in_comp;
	logic [2:0][15:0]    in_mag;
	aarm_pkg::side_t     in_side;

	logic                valid_s1;
	logic signed [35:0]  ang_s1;
	logic [2:0][31:0]    sq_s1;
	logic [2:0][15:0]    mag_s1;
	aarm_pkg::side_t     side_s1;

	always_comb begin
		in_ang   = s_axis_tdata[15:0];
		ang_full = {{2{in_ang[15]}}, in_ang, 18'd0};
		if (ang_full > aarm_pkg::Q30_PI) begin
			ang_wrap = ang_full - aarm_pkg::Q30_TWO_PI;
		end else if (ang_full < -aarm_pkg::Q30_PI) begin
			ang_wrap = ang_full + aarm_pkg::Q30_TWO_PI;
		end else begin
			ang_wrap = ang_full;
		end
		in_side = '0;
		for (int l = 0; l < 3; l++) begin
			in_comp[l]      = s_axis_tdata[16*l+16 +: 16];
			in_mag[l]       = in_comp[l][15] ? 16'(-in_comp[l]) : in_comp[l];
			in_side.zero[l] = in_mag[l] < {8'd0, tol_q};
			in_side.neg[l]  = in_comp[l][15];
			in_side.pos[l]  = !in_comp[l][15] && (in_comp[l] != 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1  <= ang_wrap;
			mag_s1  <= in_mag;
			side_s1 <= in_side;
			for (int l = 0; l < 3; l++) begin
				sq_s1[l] <= 32'(in_mag[l]) * 32'(in_mag[l]);
			end
		end
	end

	// Stage 2: fold the angle into [-pi/2, pi/2], sum the squares, seed the front chain.
	aarm_pkg::front_t   front_seed;
	aarm_pkg::front_t   front_s2;
	logic               valid_s2;
	logic signed [35:0] ang_fold;
	logic [31:0]        sq_sum;

	always_comb begin
		front_seed = '0;
		if (ang_s1 > aarm_pkg::Q30_HALF_PI) begin
			ang_fold           = aarm_pkg::Q30_PI - ang_s1;
			front_seed.neg_cos = 1'b1;
		end else if (ang_s1 < -aarm_pkg::Q30_HALF_PI) begin
			ang_fold           = -aarm_pkg::Q30_PI - ang_s1;
			front_seed.neg_cos = 1'b1;
		end else begin
			ang_fold = ang_s1;
		end
		sq_sum               = sq_s1[0] + sq_s1[1] + sq_s1[2];
		front_seed.valid     = valid_s1;
		front_seed.cx        = aarm_pkg::CORDIC_GAIN;
		front_seed.cy        = '0;
		front_seed.cz        = aarm_pkg::q30_t'(ang_fold);
		front_seed.sq_pend   = sq_sum;
		front_seed.mag       = mag_s1;
		front_seed.side      = side_s1;
		front_seed.side.zsum = (sq_sum == 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s2 <= front_seed;
		end
	end

	// Front chain: sin/cos by CORDIC and the root of (x^2+y^2+z^2) * 2^32.
	aarm_pkg::front_t front_link [aarm_pkg::FrontCells+1];

	always_comb begin
		front_link[0]       = front_s2;
		front_link[0].valid = valid_s2;
	end

	for (genvar g = 0; g < aarm_pkg::FrontCells; g++) begin : g_front
		aarm_front_cell u_front (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.idx    (5'(g)),
			.d      (front_link[g]),
			.q      (front_link[g+1])
		);
	end

	// Divider chain: each unit component is (|v| * 2^46 + root/2) / root.
	aarm_pkg::front_t front_end;
	aarm_pkg::div_t   div_link [aarm_pkg::DivCells+1];

	always_comb begin
		front_end           = front_link[aarm_pkg::FrontCells];
		div_link[0]         = '0;
		div_link[0].valid   = front_end.valid;
		div_link[0].s       = front_end.cy;
		div_link[0].c       = front_end.neg_cos ? -front_end.cx : front_end.cx;
		div_link[0].divisor = front_end.sq_root;
		div_link[0].low     = front_end.sq_root[31:1];
		div_link[0].side    = front_end.side;
		for (int l = 0; l < 3; l++) begin
			div_link[0].rem[l] = {1'b0, front_end.mag[l], 15'd0};
		end
	end

	for (genvar g = 0; g < aarm_pkg::DivCells; g++) begin : g_div
		aarm_div_cell u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.d      (div_link[g]),
			.q      (div_link[g+1])
		);
	end

	// Stage 3: signed unit components, then t*u and s*u.
	aarm_pkg::div_t  div_end;
	aarm_pkg::q30_t  unit_c [3];
	aarm_pkg::q30_t  t_c;

	logic            valid_s3;
	aarm_pkg::q30_t  tu_s3 [3];
	aarm_pkg::q30_t  su_s3 [3];
	aarm_pkg::q30_t  u_s3 [3];
	aarm_pkg::q30_t  s_s3;
	aarm_pkg::q30_t  c_s3;
	aarm_pkg::side_t side_s3;

	always_comb begin
		div_end = div_link[aarm_pkg::DivCells];
		t_c     = aarm_pkg::Q30_ONE - div_end.c;
		for (int l = 0; l < 3; l++) begin
			unit_c[l] = div_end.side.neg[l] ? -{3'b000, div_end.quo[l]} : {3'b000, div_end.quo[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= div_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				tu_s3[l] <= aarm_pkg::mul30(t_c, unit_c[l]);
				su_s3[l] <= aarm_pkg::mul30(div_end.s, unit_c[l]);
				u_s3[l]  <= unit_c[l];
			end
			s_s3    <= div_end.s;
			c_s3    <= div_end.c;
			side_s3 <= div_end.side;
		end
	end

	// Stage 4: second products, diagonal and the three cross terms.
	logic            valid_s4;
	aarm_pkg::q30_t  diag_s4 [3];
	aarm_pkg::q30_t  txy_s4;
	aarm_pkg::q30_t  txz_s4;
	aarm_pkg::q30_t  tyz_s4;
	aarm_pkg::q30_t  su_s4 [3];
	aarm_pkg::q30_t  s_s4;
	aarm_pkg::q30_t  c_s4;
	aarm_pkg::side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				diag_s4[l] <= aarm_pkg::mul30(tu_s3[l], u_s3[l]);
				su_s4[l]   <= su_s3[l];
			end
			txy_s4  <= aarm_pkg::mul30(tu_s3[0], u_s3[1]);
			txz_s4  <= aarm_pkg::mul30(tu_s3[0], u_s3[2]);
			tyz_s4  <= aarm_pkg::mul30(tu_s3[1], u_s3[2]);
			s_s4    <= s_s3;
			c_s4    <= c_s3;
			side_s4 <= side_s3;
		end
	end

	// Output stage: sums, rounding to Q2.14 and the shortcut cases.
	logic        sel_id;
	logic        sel_x;
	logic        sel_y;
	logic        sel_z;
	logic [15:0] qc;
	logic [15:0] qs_pos;
	logic [15:0] qs_neg;
	logic [15:0] res [9];
	logic [143:0] out_data_q;

	always_comb begin
		sel_id = (&side_s4.zero) || side_s4.zsum;
		sel_x  = !sel_id && side_s4.zero[1] && side_s4.zero[2];
		sel_y  = !sel_id && !sel_x && side_s4.zero[0] && side_s4.zero[2];
		sel_z  = !sel_id && !sel_x && !sel_y && side_s4.zero[0] && side_s4.zero[1];
		qc     = aarm_pkg::q214_of(c_s4, '0);
		qs_pos = aarm_pkg::q214_of(s_s4, '0);
		qs_neg = aarm_pkg::q214_of(-s_s4, '0);

		res[0] = aarm_pkg::q214_of(diag_s4[0], c_s4);
		res[1] = aarm_pkg::q214_of(txy_s4, -su_s4[2]);
		res[2] = aarm_pkg::q214_of(txz_s4, su_s4[1]);
		res[3] = aarm_pkg::q214_of(txy_s4, su_s4[2]);
		res[4] = aarm_pkg::q214_of(diag_s4[1], c_s4);
		res[5] = aarm_pkg::q214_of(tyz_s4, -su_s4[0]);
		res[6] = aarm_pkg::q214_of(txz_s4, -su_s4[1]);
		res[7] = aarm_pkg::q214_of(tyz_s4, su_s4[0]);
		res[8] = aarm_pkg::q214_of(diag_s4[2], c_s4);

		if (sel_id || sel_x || sel_y || sel_z) begin
			for (int k = 0; k < 9; k++) begin
				res[k] = 16'd0;
			end
		end
		if (sel_id) begin
			res[0] = aarm_pkg::Q214_ONE;
			res[4] = aarm_pkg::Q214_ONE;
			res[8] = aarm_pkg::Q214_ONE;
		end
		// Rotation about x alone.
		if (sel_x) begin
			res[0] = aarm_pkg::Q214_ONE;
			res[4] = qc;
			res[8] = qc;
			res[5] = side_s4.pos[0] ? qs_neg : qs_pos;
			res[7] = side_s4.pos[0] ? qs_pos : qs_neg;
		end
		// Rotation about y alone.
		if (sel_y) begin
			res[4] = aarm_pkg::Q214_ONE;
			res[0] = qc;
			res[8] = qc;
			res[2] = side_s4.pos[1] ? qs_pos : qs_neg;
			res[6] = side_s4.pos[1] ? qs_neg : qs_pos;
		end
		// Rotation about z alone.
		if (sel_z) begin
			res[8] = aarm_pkg::Q214_ONE;
			res[0] = qc;
			res[4] = qc;
			res[1] = side_s4.pos[2] ? qs_neg : qs_pos;
			res[3] = side_s4.pos[2] ? qs_pos : qs_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {res[8], res[7], res[6], res[5], res[4],
				res[3], res[2], res[1], res[0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// A waiting result that is not taken must freeze the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while the output is stalled");

	// At most one of the special cases steers the output stage of a live item.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> $onehot0({sel_id, sel_x, sel_y, sel_z}))
		else $error("more than one special case selected");

	// A tolerance write lands in the register.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (tol_q == $past(pwdata[7:0])))
		else $error("tolerance register not updated");

	// A nonzero axis never gives a unit component above one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_end.valid && !div_end.side.zsum) |->
		((div_end.quo[0] <= 31'h40000000) && (div_end.quo[1] <= 31'h40000000)
		&& (div_end.quo[2] <= 31'h40000000)))
		else $error("unit component out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/aarm_front_cell.sv */
// One cell of the front chain: a CORDIC rotation step and a square root digit step.
// Uses aarm_pkg for the item state type and the arctangent table.
`default_nettype none

module aarm_front_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [4:0]        idx,
	input  aarm_pkg::front_t  d,
	output aarm_pkg::front_t  q
);

	aarm_pkg::front_t nxt;
	aarm_pkg::front_t pay_q;
	logic             valid_q;
	aarm_pkg::q30_t   dx;
	aarm_pkg::q30_t   dy;
	aarm_pkg::q30_t   ang;
	logic [34:0]      sq_acc;
	logic [34:0]      sq_trial;

	always_comb begin
		nxt = d;
		dx  = d.cy >>> idx;
		dy  = d.cx >>> idx;
		ang = {2'b00, aarm_pkg::STEP_ANGLE[idx]};
		// Cells past the last rotation step only carry the vector on.
		if (idx < 5'(aarm_pkg::CordicSteps)) begin
			if (!d.cz[33]) begin
				nxt.cx = d.cx - dx;
				nxt.cy = d.cy + dy;
				nxt.cz = d.cz - ang;
			end else begin
				nxt.cx = d.cx + dx;
				nxt.cy = d.cy - dy;
				nxt.cz = d.cz + ang;
			end
		end
		sq_acc   = {d.sq_rem[32:0], d.sq_pend[31:30]};
		sq_trial = {1'b0, d.sq_root, 2'b01};
		if (sq_acc >= sq_trial) begin
			nxt.sq_rem  = sq_acc - sq_trial;
			nxt.sq_root = {d.sq_root[30:0], 1'b1};
		end else begin
			nxt.sq_rem  = sq_acc;
			nxt.sq_root = {d.sq_root[30:0], 1'b0};
		end
		nxt.sq_pend = {d.sq_pend[29:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		q       = pay_q;
		q.valid = valid_q;
	end

endmodule

`default_nettype wire

/* hw/rtl/aarm_div_cell.sv */
// One cell of the divider chain: one restoring quotient bit for each of three lanes.
// Uses aarm_pkg for the item state type.
`default_nettype none

module aarm_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  aarm_pkg::div_t  d,
	output aarm_pkg::div_t  q
);

	aarm_pkg::div_t nxt;
	aarm_pkg::div_t pay_q;
	logic           valid_q;
	logic [32:0]    acc;
	logic [32:0]    diff;

	always_comb begin
		nxt  = d;
		acc  = '0;
		diff = '0;
		for (int l = 0; l < 3; l++) begin
			acc  = {d.rem[l], d.low[30]};
			diff = acc - {1'b0, d.divisor};
			if (!diff[32]) begin
				nxt.rem[l] = diff[31:0];
				nxt.quo[l] = {d.quo[l][29:0], 1'b1};
			end else begin
				nxt.rem[l] = acc[31:0];
				nxt.quo[l] = {d.quo[l][29:0], 1'b0};
			end
		end
		nxt.low = {d.low[29:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		q       = pay_q;
		q.valid = valid_q;
	end

endmodule

`default_nettype wire
